FILE: hw/rtl/vgr_pkg.sv
// Shared types, codes and constants of the variable-width glyph rasterizer.
`default_nettype none

package vgr_pkg;

  // Default sizes of the font storage and of the glyph limits.
  localparam int unsigned DEF_MAX_GLYPHS  = 256;
  localparam int unsigned DEF_ATLAS_BYTES = 16384;
  localparam int unsigned DEF_MAX_WIDTH   = 64;
  localparam int unsigned DEF_MAX_HEIGHT  = 32;

  // Most rows that one render may emit.
  localparam int unsigned RESULT_CAP = 32;

  // Port widths.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned S_TDATA_W  = 88;
  localparam int unsigned S_TUSER_W  = 2;
  localparam int unsigned M_TDATA_W  = 120;
  localparam int unsigned M_TUSER_W  = 1;

  // Internal widths.
  localparam int unsigned ROW_BITS_W = 64;
  localparam int unsigned WIDTH_W    = 7;
  localparam int unsigned ROW_W      = 6;
  localparam int unsigned BIT_ADDR_W = 21;
  localparam int unsigned BYTE_ADDR_W = BIT_ADDR_W - 2;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned STREAM_W   = 72;

  // Command codes carried on the input tuser.
  localparam logic [S_TUSER_W-1:0] CMD_LOAD_OFFSET = 2'd0;
  localparam logic [S_TUSER_W-1:0] CMD_LOAD_ATLAS  = 2'd1;
  localparam logic [S_TUSER_W-1:0] CMD_RENDER      = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_CODE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_ROWS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_PITCH = 2'd3;

  // Configuration reset values.
  localparam logic [7:0]  RST_FIRST_CODE  = 8'd32;
  localparam logic [8:0]  RST_END_CODE    = 9'd127;
  localparam logic [5:0]  RST_GLYPH_ROWS  = 6'd8;
  localparam logic [11:0] RST_ATLAS_PITCH = 12'd128;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK0,
    ST_LOOK1,
    ST_LOOK2,
    ST_ROW,
    ST_FETCH,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ld_offset;
    logic ld_atlas;
    logic take;
    logic rd_first;
    logic rd_next;
    logic set_glyph;
    logic row_init;
    logic issue;
    logic emit;
    logic row_next;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic code_ok;
    logic glyph_ok;
    logic last_issue;
    logic last_row;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/vgr_ctrl.sv
// Controller state machine of the glyph rasterizer.
`default_nettype none

module vgr_ctrl (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  input  wire logic [vgr_pkg::S_TUSER_W-1:0]      s_axis_tuser,
  output logic                                    s_axis_tready,
  input  wire vgr_pkg::dp_stat_t                  stat_i,
  output vgr_pkg::dp_cmd_t                        cmd_o
);

  vgr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vgr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      vgr_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          unique case (s_axis_tuser)
            vgr_pkg::CMD_LOAD_OFFSET: cmd_o.ld_offset = 1'b1;
            vgr_pkg::CMD_LOAD_ATLAS:  cmd_o.ld_atlas  = 1'b1;
            vgr_pkg::CMD_RENDER: begin
              cmd_o.take = 1'b1;
              state_d    = vgr_pkg::ST_LOOK0;
            end
            default: ;
          endcase
        end
      end
      vgr_pkg::ST_LOOK0: begin
        if (stat_i.code_ok) begin
          cmd_o.rd_first = 1'b1;
          state_d        = vgr_pkg::ST_LOOK1;
        end else begin
          state_d = vgr_pkg::ST_IDLE;
        end
      end
      vgr_pkg::ST_LOOK1: begin
        cmd_o.rd_next = 1'b1;
        state_d       = vgr_pkg::ST_LOOK2;
      end
      vgr_pkg::ST_LOOK2: begin
        if (stat_i.glyph_ok) begin
          cmd_o.set_glyph = 1'b1;
          state_d         = vgr_pkg::ST_ROW;
        end else begin
          state_d = vgr_pkg::ST_IDLE;
        end
      end
      vgr_pkg::ST_ROW: begin
        cmd_o.row_init = 1'b1;
        state_d        = vgr_pkg::ST_FETCH;
      end
      vgr_pkg::ST_FETCH: begin
        cmd_o.issue = 1'b1;
        if (stat_i.last_issue) begin
          state_d = vgr_pkg::ST_DRAIN;
        end
      end
      vgr_pkg::ST_DRAIN: begin
        state_d = vgr_pkg::ST_EMIT;
      end
      vgr_pkg::ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.last_row) begin
            state_d = vgr_pkg::ST_IDLE;
          end else begin
            cmd_o.row_next = 1'b1;
            state_d        = vgr_pkg::ST_ROW;
          end
        end
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/vgr_datapath.sv
// Datapath of the glyph rasterizer: config registers, font memories and row gathering.
`default_nettype none

module vgr_datapath #(
  parameter int unsigned MAX_GLYPHS  = vgr_pkg::DEF_MAX_GLYPHS,
  parameter int unsigned ATLAS_BYTES = vgr_pkg::DEF_ATLAS_BYTES,
  parameter int unsigned MAX_WIDTH   = vgr_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT  = vgr_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [vgr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [vgr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic [vgr_pkg::S_TDATA_W-1:0]      s_tdata_i,
  input  wire vgr_pkg::dp_cmd_t                   cmd_i,
  output vgr_pkg::dp_stat_t                       stat_o,
  output logic                                    m_tvalid_o,
  input  wire logic                               m_tready_i,
  output logic [vgr_pkg::M_TDATA_W-1:0]           m_tdata_o,
  output logic [vgr_pkg::M_TUSER_W-1:0]           m_tuser_o,
  output logic                                    m_tlast_o
);

  localparam int unsigned ROW_LIMIT =
      (MAX_HEIGHT < vgr_pkg::RESULT_CAP) ? MAX_HEIGHT : vgr_pkg::RESULT_CAP;
  localparam int unsigned OFF_DEPTH = MAX_GLYPHS + 1;
  localparam int unsigned OFF_AW    = $clog2(OFF_DEPTH);
  localparam int unsigned ATL_AW    = $clog2(ATLAS_BYTES);
  localparam int unsigned BW        = vgr_pkg::BIT_ADDR_W;

  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7-i];
    end
    return r;
  endfunction

  // Input beat fields.
  logic [7:0]  in_code;
  logic [15:0] in_px, in_py, in_ink;
  logic [13:0] in_lidx;
  logic [16:0] in_lval, lidx_ext;

  assign in_code  = s_tdata_i[7:0];
  assign in_px    = s_tdata_i[23:8];
  assign in_py    = s_tdata_i[39:24];
  assign in_ink   = s_tdata_i[55:40];
  assign in_lidx  = s_tdata_i[69:56];
  assign in_lval  = s_tdata_i[86:70];
  assign lidx_ext = 17'(in_lidx);

  // Configuration registers.
  logic [7:0]  first_q;
  logic [8:0]  end_q;
  logic [5:0]  grows_q;
  logic [11:0] pitch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= vgr_pkg::RST_FIRST_CODE;
      end_q   <= vgr_pkg::RST_END_CODE;
      grows_q <= vgr_pkg::RST_GLYPH_ROWS;
      pitch_q <= vgr_pkg::RST_ATLAS_PITCH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vgr_pkg::REG_FIRST_CODE:  first_q <= cfg_data_i[7:0];
        vgr_pkg::REG_END_CODE:    end_q   <= cfg_data_i[8:0];
        vgr_pkg::REG_GLYPH_ROWS:  grows_q <= cfg_data_i[5:0];
        vgr_pkg::REG_ATLAS_PITCH: pitch_q <= cfg_data_i;
      endcase
    end
  end

  // Render item fields held for the whole glyph.
  logic [7:0]  code_q;
  logic [15:0] px_q, py_q, ink_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      code_q <= in_code;
      px_q   <= in_px;
      py_q   <= in_py;
      ink_q  <= in_ink;
    end
  end

  // Offset table.
  logic [16:0] offset_mem_q [OFF_DEPTH];
  logic [16:0] off_rdata_q;
  logic [7:0]  gi;
  logic [8:0]  off_raddr;

  assign gi        = code_q - first_q;
  assign off_raddr = cmd_i.rd_next ? ({1'b0, gi} + 9'd1) : {1'b0, gi};

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_offset && (in_lidx <= 14'(MAX_GLYPHS))) begin
      offset_mem_q[in_lidx[OFF_AW-1:0]] <= in_lval;
    end
    if (cmd_i.rd_first || cmd_i.rd_next) begin
      off_rdata_q <= offset_mem_q[off_raddr[OFF_AW-1:0]];
    end
  end

  // Atlas store.
  logic [7:0]  atlas_mem_q [ATLAS_BYTES];
  logic [7:0]  atl_rdata_q;
  logic        pend_q, oob_q;
  logic [vgr_pkg::SLOT_W-1:0] slot_q, j_q;
  logic [vgr_pkg::BYTE_ADDR_W-1:0] byte_addr;
  logic [BW-1:0] base_q;

  assign byte_addr = {1'b0, base_q[BW-1:3]} + vgr_pkg::BYTE_ADDR_W'(j_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_atlas && (lidx_ext < 17'(ATLAS_BYTES))) begin
      atlas_mem_q[lidx_ext[ATL_AW-1:0]] <= in_lval[7:0];
    end
    if (cmd_i.issue) begin
      atl_rdata_q <= atlas_mem_q[byte_addr[ATL_AW-1:0]];
      slot_q      <= j_q;
      oob_q       <= byte_addr >= vgr_pkg::BYTE_ADDR_W'(ATLAS_BYTES);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.issue;
    end
  end

  // Glyph geometry.
  logic [16:0] start_q, diff;
  logic [vgr_pkg::WIDTH_W-1:0] width_q, span;
  logic        clip_q;
  logic [vgr_pkg::ROW_W-1:0] rows_q, y_q, rows_lim;

  assign diff     = off_rdata_q - start_q;
  assign rows_lim = (grows_q > vgr_pkg::ROW_W'(ROW_LIMIT)) ?
                    vgr_pkg::ROW_W'(ROW_LIMIT) : grows_q;
  assign span     = vgr_pkg::WIDTH_W'(base_q[2:0]) + width_q - 7'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_next) begin
      start_q <= off_rdata_q;
    end
    if (cmd_i.set_glyph) begin
      if (diff > 17'(MAX_WIDTH)) begin
        width_q <= vgr_pkg::WIDTH_W'(MAX_WIDTH);
        clip_q  <= 1'b1;
      end else begin
        width_q <= diff[vgr_pkg::WIDTH_W-1:0];
        clip_q  <= 1'b0;
      end
      rows_q <= rows_lim;
      y_q    <= '0;
      base_q <= BW'(start_q);
    end else if (cmd_i.row_next) begin
      y_q    <= y_q + 6'd1;
      base_q <= base_q + BW'({pitch_q, 3'b000});
    end
    if (cmd_i.row_init) begin
      j_q <= '0;
    end else if (cmd_i.issue) begin
      j_q <= j_q + 4'd1;
    end
  end

  // Row bit stream: bit i is atlas bit i counted from the MSB of the first byte.
  logic [vgr_pkg::STREAM_W-1:0]   stream_q, shifted;
  logic [vgr_pkg::ROW_BITS_W-1:0] row_bits;

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_init) begin
      stream_q <= '0;
    end else if (pend_q) begin
      stream_q[{slot_q, 3'b000} +: 8] <= oob_q ? 8'h00 : rev8(atl_rdata_q);
    end
  end

  assign shifted = stream_q >> base_q[2:0];

  always_comb begin
    for (int i = 0; i < vgr_pkg::ROW_BITS_W; i++) begin
      row_bits[i] = shifted[i] & (vgr_pkg::WIDTH_W'(i) < width_q);
    end
  end

  // Output register.
  logic        out_valid_q;
  logic [15:0] ox_q, oy_q, oink_q;
  logic [vgr_pkg::ROW_BITS_W-1:0] obits_q;
  logic [vgr_pkg::WIDTH_W-1:0]    owidth_q;
  logic        oclip_q, olast_q;
  logic        last_row;

  assign last_row = (y_q == rows_q - 6'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      ox_q     <= px_q;
      oy_q     <= py_q + 16'(y_q);
      obits_q  <= row_bits;
      owidth_q <= width_q;
      oink_q   <= ink_q;
      oclip_q  <= clip_q;
      olast_q  <= last_row;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {1'b0, oink_q, owidth_q, obits_q, oy_q, ox_q};
  assign m_tuser_o  = oclip_q;
  assign m_tlast_o  = olast_q;

  // Status.
  assign stat_o.code_ok    = (code_q >= first_q) && ({1'b0, code_q} < end_q) &&
                             ({1'b0, gi} < 9'(MAX_GLYPHS));
  assign stat_o.glyph_ok   = (off_rdata_q > start_q) && (rows_lim != '0);
  assign stat_o.last_issue = (j_q == span[6:3]);
  assign stat_o.last_row   = last_row;
  assign stat_o.out_free   = !out_valid_q || m_tready_i;

endmodule

`default_nettype wire

FILE: hw/rtl/variable_width_glyph_rasterizer_top.sv
// Top level of the variable-width glyph rasterizer: controller, datapath and checks.
//
// Input channel (s_axis): each beat is one command, chosen by tuser. A load-offset beat
// writes one entry of the glyph bit-offset table, a load-atlas beat writes one font
// atlas byte, and a render beat draws one character; a load keeps the input ready.
// Output channel (m_axis): a render produces one beat per glyph row, carrying the row
// position, the gathered pixel bits, the glyph width and the colour; tlast marks the
// final row and tuser flags a width that was clipped to the maximum.
// A render first checks the code and makes the two offset lookups, then for each row
// clears the gather register, fetches the n atlas bytes the row spans (n is 1 to 9),
// waits for the last byte and writes the row out; the single atlas read port fetches
// one byte per cycle and so sets the pace of a row.
// Renders that hit a code outside the font or a glyph of zero width emit nothing.
// When the receiver stalls, the finished row waits in the output register and the
// next row waits in the datapath until it is taken; new beats are taken again once
// the render is done, even if the final row has not yet been taken.
// Reset sets the configuration registers to their defaults; the offset table and the
// atlas are not cleared and must be loaded before they are read.
`default_nettype none

module variable_width_glyph_rasterizer_top #(
  parameter int unsigned MAX_GLYPHS  = vgr_pkg::DEF_MAX_GLYPHS,
  parameter int unsigned ATLAS_BYTES = vgr_pkg::DEF_ATLAS_BYTES,
  parameter int unsigned MAX_WIDTH   = vgr_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT  = vgr_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [vgr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [vgr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // From bit 0: char_code(8), pos_x(16), pos_y(16), ink(16), load_index(14),
  // load_value(17), one zero pad bit.
  input  wire logic [vgr_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // From bit 0: cmd(2).
  input  wire logic [vgr_pkg::S_TUSER_W-1:0]      s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // From bit 0: row_x(16), row_y(16), row_bits(64), glyph_width(7), row_ink(16),
  // one zero pad bit.
  output logic [vgr_pkg::M_TDATA_W-1:0]           m_axis_tdata,
  // From bit 0: width_clipped(1).
  output logic [vgr_pkg::M_TUSER_W-1:0]           m_axis_tuser,
  output logic                                    m_axis_tlast
);

  vgr_pkg::dp_cmd_t  dp_cmd;
  vgr_pkg::dp_stat_t dp_stat;

  // The controller only sequences; it sees the input handshake and the datapath status.
  vgr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tready (s_axis_tready),
    .stat_i        (dp_stat),
    .cmd_o         (dp_cmd)
  );

  // The datapath holds the font memories, the row gathering logic and the output register.
  vgr_datapath #(
    .MAX_GLYPHS  (MAX_GLYPHS),
    .ATLAS_BYTES (ATLAS_BYTES),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tdata_i  (s_axis_tdata),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

  // The input must be closed right after a render beat is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == vgr_pkg::CMD_RENDER))
    |=> !s_axis_tready)
  else $error("input accepted right after a render beat");

  // A row is only written into the output register when that register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.emit |-> dp_stat.out_free)
  else $error("row emitted over a pending output beat");

  // Every emitted row carries a width between one and the maximum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[102:96] != 7'd0) &&
                       (m_axis_tdata[102:96] <= 7'(MAX_WIDTH))))
  else $error("glyph width out of range on output");

  // A clipped glyph reports exactly the maximum width.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[102:96] == 7'(MAX_WIDTH)))
  else $error("clipped glyph without saturated width");

endmodule

`default_nettype wire
